/* rtl/core/qtt_pkg.sv */
// ----------------------------------------------------------------------------
// qtt_pkg
// Types, constants and helper functions shared by the query text tokenizer.
// ----------------------------------------------------------------------------
package qtt_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DASH,
    PH_SIGN,
    PH_DIGITS,
    PH_IDENT,
    PH_STRING,
    PH_ERRDROP,
    PH_ENDDROP
  } phase_t;

  // token classes
  localparam logic [3:0] CL_IDENT   = 4'd0;
  localparam logic [3:0] CL_KEYWORD = 4'd1;
  localparam logic [3:0] CL_DASH    = 4'd2;
  localparam logic [3:0] CL_LBRACK  = 4'd3;
  localparam logic [3:0] CL_RBRACK  = 4'd4;
  localparam logic [3:0] CL_LT      = 4'd5;
  localparam logic [3:0] CL_GT      = 4'd6;
  localparam logic [3:0] CL_EQ      = 4'd7;
  localparam logic [3:0] CL_NUMBER  = 4'd8;
  localparam logic [3:0] CL_LPAREN  = 4'd9;
  localparam logic [3:0] CL_RPAREN  = 4'd10;
  localparam logic [3:0] CL_COMMA   = 4'd11;
  localparam logic [3:0] CL_STRING  = 4'd12;

  // error codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_BAD_START   = 2'd1;
  localparam logic [1:0] ERR_SECOND_DOT  = 2'd2;
  localparam logic [1:0] ERR_OPEN_STRING = 2'd3;

  // keyword index
  localparam logic KW_SELECT = 1'b0;
  localparam logic KW_RETURN = 1'b1;

  // byte codes
  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_FF         = 8'hFF;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_QUOTE      = 8'h22;
  localparam logic [7:0] CH_DOT        = 8'h2E;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;

  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned RES_CNT_W   = 2;

  typedef struct packed {
    logic [7:0] out_char;
    logic [3:0] token_class;
    logic       token_first;
    logic       token_last;
    logic       keyword_index;
    logic       text_end;
    logic [1:0] error_code;
  } qtt_result_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] held_byte;
    logic       held_valid;
    logic [3:0] held_class;
    logic       held_is_first;
    logic       dot_seen;
    logic       escape_pending;
    logic [2:0] word_length;
    logic [1:0] keyword_alive;
    logic       error_seen;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{
    phase: PH_IDLE, held_byte: 8'h00, held_valid: 1'b0, held_class: CL_IDENT,
    held_is_first: 1'b0, dot_seen: 1'b0, escape_pending: 1'b0,
    word_length: 3'd0, keyword_alive: 2'b00, error_seen: 1'b0
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // space, tab, newline, vertical tab, form feed, carriage return
  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [3:0] single_class(logic [7:0] c);
    logic [3:0] cls;
    case (c)
      "[":     cls = CL_LBRACK;
      "]":     cls = CL_RBRACK;
      "<":     cls = CL_LT;
      ">":     cls = CL_GT;
      "=":     cls = CL_EQ;
      "(":     cls = CL_LPAREN;
      ")":     cls = CL_RPAREN;
      ",":     cls = CL_COMMA;
      default: cls = CL_IDENT;
    endcase
    return cls;
  endfunction

  function automatic logic [7:0] kw_select_char(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "s";
      3'd1:    ch = "e";
      3'd2:    ch = "l";
      3'd3:    ch = "e";
      3'd4:    ch = "c";
      3'd5:    ch = "t";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] kw_return_char(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "r";
      3'd1:    ch = "e";
      3'd2:    ch = "t";
      3'd3:    ch = "u";
      3'd4:    ch = "r";
      3'd5:    ch = "n";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // bit 0 of keyword_alive tracks "select", bit 1 tracks "return"
  function automatic lex_state_t kw_track(lex_state_t st, logic [7:0] c);
    lex_state_t s;
    logic [7:0] lc;
    s  = st;
    lc = ((c >= "A") && (c <= "Z")) ? (c + 8'd32) : c;
    if (s.word_length >= 3'd6) begin
      s.keyword_alive = 2'b00;
    end else begin
      if (lc != kw_select_char(s.word_length)) s.keyword_alive[0] = 1'b0;
      if (lc != kw_return_char(s.word_length)) s.keyword_alive[1] = 1'b0;
    end
    if (s.word_length < 3'd7) s.word_length = s.word_length + 3'd1;
    return s;
  endfunction

  function automatic qtt_result_t mk_res(logic [7:0] ch, logic [3:0] cls, logic first,
                                         logic last, logic kw, logic tend,
                                         logic [1:0] err);
    qtt_result_t r;
    r.out_char      = ch;
    r.token_class   = cls;
    r.token_first   = first;
    r.token_last    = last;
    r.keyword_index = kw;
    r.text_end      = tend;
    r.error_code    = err;
    return r;
  endfunction

  // held byte as a result; on the last byte an identifier may turn keyword
  function automatic qtt_result_t flush_res(lex_state_t st, logic last);
    logic [3:0] cls;
    logic       kw;
    cls = st.held_class;
    kw  = KW_SELECT;
    if (last && (st.phase == PH_IDENT) && (st.word_length == 3'd6) &&
        (st.keyword_alive != 2'b00)) begin
      cls = CL_KEYWORD;
      kw  = st.keyword_alive[0] ? KW_SELECT : KW_RETURN;
    end
    return mk_res(st.held_byte, cls, st.held_is_first, last, kw, 1'b0, ERR_NONE);
  endfunction

endpackage

/* rtl/core/qtt_ifs.sv */
// ----------------------------------------------------------------------------
// qtt_ifs
// Valid/ready channels of the query text tokenizer: byte input, token output.
// ----------------------------------------------------------------------------
interface qtt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       in_last;

  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface qtt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [3:0] token_class;
  logic       token_first;
  logic       token_last;
  logic       keyword_index;
  logic       text_end;
  logic [1:0] error_code;

  modport source (output valid, out_char, token_class, token_first, token_last,
                  keyword_index, text_end, error_code, input ready);
  modport sink   (input valid, out_char, token_class, token_first, token_last,
                  keyword_index, text_end, error_code, output ready);
endinterface

/* rtl/core/qtt_lexer.sv */
// ----------------------------------------------------------------------------
// qtt_lexer
// Next-state and result logic for one byte: up to three results per byte.
// ----------------------------------------------------------------------------
module qtt_lexer (
  input  qtt_pkg::lex_state_t  st_i,
  input  logic [7:0]           in_char_i,
  input  logic                 in_last_i,
  output qtt_pkg::lex_state_t  st_nxt_o,
  output qtt_pkg::qtt_result_t res_o [qtt_pkg::MAX_RESULTS],
  output logic [qtt_pkg::RES_CNT_W-1:0] res_cnt_o
);
  import qtt_pkg::*;

  lex_state_t         s;
  qtt_result_t        r [MAX_RESULTS];
  logic [RES_CNT_W-1:0] n;
  logic               nul;
  logic               act_next, act_end, act_start, act_err2, act_quote;
  logic [3:0]         sc;
  logic [1:0]         err;
  logic [7:0]         c;

  assign c = in_char_i;

  always_comb begin
    s         = st_i;
    n         = '0;
    act_next  = 1'b0;
    act_end   = 1'b0;
    act_start = 1'b0;
    act_err2  = 1'b0;
    act_quote = 1'b0;
    sc        = CL_IDENT;
    err       = ERR_NONE;
    for (int i = 0; i < MAX_RESULTS; i++) r[i] = '0;
    nul = (c == CH_NUL) || (c == CH_FF);

    if (st_i.phase == PH_ENDDROP) begin
      if (in_last_i) s = LEX_RESET;
    end else begin
      if (!nul) begin
        // decide what this byte does to the held token
        case (s.phase)
          PH_IDLE: act_start = 1'b1;
          PH_DASH: begin
            if (is_digit(c) || (c == CH_DOT) || (c == CH_PLUS)) begin
              s.held_class = CL_NUMBER;
              s.dot_seen   = (c == CH_DOT);
              s.phase      = (c == CH_PLUS) ? PH_SIGN : PH_DIGITS;
              act_next     = 1'b1;
            end else begin
              act_end   = 1'b1;
              act_start = 1'b1;
            end
          end
          PH_SIGN: begin
            if ((c == CH_PLUS) || (c == CH_MINUS)) begin
              act_next = 1'b1;
            end else if (is_digit(c) || (c == CH_DOT)) begin
              s.dot_seen = (c == CH_DOT);
              s.phase    = PH_DIGITS;
              act_next   = 1'b1;
            end else begin
              act_end   = 1'b1;
              act_start = 1'b1;
            end
          end
          PH_DIGITS: begin
            if (is_digit(c)) begin
              act_next = 1'b1;
            end else if (c == CH_DOT) begin
              if (s.dot_seen) begin
                act_end  = 1'b1;
                act_err2 = 1'b1;
              end else begin
                s.dot_seen = 1'b1;
                act_next   = 1'b1;
              end
            end else begin
              act_end   = 1'b1;
              act_start = 1'b1;
            end
          end
          PH_IDENT: begin
            if (is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE)) begin
              s        = kw_track(s, c);
              act_next = 1'b1;
            end else begin
              act_end   = 1'b1;
              act_start = 1'b1;
            end
          end
          PH_STRING: begin
            if (s.escape_pending) begin
              s.escape_pending = 1'b0;
              act_next         = 1'b1;
            end else if (c == CH_BACKSLASH) begin
              s.escape_pending = 1'b1;
            end else if (c == CH_QUOTE) begin
              act_quote = 1'b1;
            end else begin
              act_next = 1'b1;
            end
          end
          default: ;
        endcase

        // held byte goes out as a middle byte
        if ((act_next || act_quote) && s.held_valid) begin
          if (n != RES_CNT_W'(MAX_RESULTS)) begin
            r[n] = flush_res(s, 1'b0);
            n    = n + 1'b1;
          end
          s.held_is_first = 1'b0;
        end
        if (act_next) begin
          s.held_byte  = c;
          s.held_valid = 1'b1;
        end
        if (act_quote) begin
          s.held_valid = 1'b0;
          if (n != RES_CNT_W'(MAX_RESULTS)) begin
            r[n] = mk_res(c, CL_STRING, 1'b0, 1'b1, KW_SELECT, 1'b0, ERR_NONE);
            n    = n + 1'b1;
          end
          s.phase = PH_IDLE;
        end

        // held byte closes its token
        if (act_end && s.held_valid) begin
          if (n != RES_CNT_W'(MAX_RESULTS)) begin
            r[n] = flush_res(s, 1'b1);
            n    = n + 1'b1;
          end
          s.held_is_first = 1'b0;
          s.held_valid    = 1'b0;
        end
        if (act_err2) begin
          if (n != RES_CNT_W'(MAX_RESULTS)) begin
            r[n] = mk_res(c, CL_IDENT, 1'b0, 1'b0, KW_SELECT, 1'b0, ERR_SECOND_DOT);
            n    = n + 1'b1;
          end
          s.error_seen = 1'b1;
          s.held_valid = 1'b0;
          s.phase      = PH_ERRDROP;
        end

        // byte opens a new token
        if (act_start) begin
          s.phase = PH_IDLE;
          if (!is_space(c)) begin
            sc = single_class(c);
            if (c == CH_MINUS) begin
              s.held_byte = c; s.held_valid = 1'b1; s.held_is_first = 1'b1;
              s.held_class = CL_DASH; s.phase = PH_DASH;
            end else if (c == CH_PLUS) begin
              s.held_byte = c; s.held_valid = 1'b1; s.held_is_first = 1'b1;
              s.held_class = CL_NUMBER; s.phase = PH_SIGN;
            end else if (c == CH_QUOTE) begin
              s.escape_pending = 1'b0;
              s.held_byte = c; s.held_valid = 1'b1; s.held_is_first = 1'b1;
              s.held_class = CL_STRING; s.phase = PH_STRING;
            end else if (sc != CL_IDENT) begin
              if (n != RES_CNT_W'(MAX_RESULTS)) begin
                r[n] = mk_res(c, sc, 1'b1, 1'b1, KW_SELECT, 1'b0, ERR_NONE);
                n    = n + 1'b1;
              end
            end else if (is_digit(c)) begin
              s.dot_seen = 1'b0;
              s.held_byte = c; s.held_valid = 1'b1; s.held_is_first = 1'b1;
              s.held_class = CL_NUMBER; s.phase = PH_DIGITS;
            end else if (is_alpha(c) || (c == CH_COLON) || (c == CH_UNDERSCORE)) begin
              s.word_length   = 3'd0;
              s.keyword_alive = 2'b11;
              s               = kw_track(s, c);
              s.held_byte = c; s.held_valid = 1'b1; s.held_is_first = 1'b1;
              s.held_class = CL_IDENT; s.phase = PH_IDENT;
            end else begin
              if (n != RES_CNT_W'(MAX_RESULTS)) begin
                r[n] = mk_res(c, CL_IDENT, 1'b0, 1'b0, KW_SELECT, 1'b0, ERR_BAD_START);
                n    = n + 1'b1;
              end
              s.error_seen = 1'b1;
              s.held_valid = 1'b0;
              s.phase      = PH_ERRDROP;
            end
          end
        end
      end

      // end of text: close the held token, then the marker
      if (nul || in_last_i) begin
        err = (s.phase == PH_STRING) ? ERR_OPEN_STRING : ERR_NONE;
        if ((s.phase != PH_ERRDROP) && s.held_valid) begin
          if (n != RES_CNT_W'(MAX_RESULTS)) begin
            r[n] = flush_res(s, 1'b1);
            n    = n + 1'b1;
          end
        end
        if (n != RES_CNT_W'(MAX_RESULTS)) begin
          r[n] = mk_res(8'h00, CL_IDENT, 1'b0, 1'b0, KW_SELECT, 1'b1, err);
          n    = n + 1'b1;
        end
        s = LEX_RESET;
        if (nul && !in_last_i) s.phase = PH_ENDDROP;
      end
    end
  end

  assign st_nxt_o  = s;
  assign res_o     = r;
  assign res_cnt_o = n;

endmodule

/* rtl/core/qtt_result_buf.sv */
// ----------------------------------------------------------------------------
// qtt_result_buf
// Holds the results of one byte and hands them out one per cycle while pop_i is high.
// ----------------------------------------------------------------------------
module qtt_result_buf (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load_i,
  input  logic [qtt_pkg::RES_CNT_W-1:0] load_cnt_i,
  input  qtt_pkg::qtt_result_t          load_data_i [qtt_pkg::MAX_RESULTS],
  input  logic                          pop_i,
  output logic                          valid_o,
  output qtt_pkg::qtt_result_t          data_o,
  output logic                          free_o
);
  import qtt_pkg::*;

  qtt_result_t          data_r [MAX_RESULTS];
  logic [RES_CNT_W-1:0] rd_r, rd_nxt;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 fire;

  assign valid_o = (cnt_r != '0);
  assign fire    = valid_o && pop_i;
  // empty after this cycle, so a new byte's results may be loaded
  assign free_o  = (cnt_r == '0) || ((cnt_r == RES_CNT_W'(1)) && pop_i);

  always_comb begin
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (load_i) begin
      rd_nxt  = '0;
      cnt_nxt = load_cnt_i;
    end else if (fire) begin
      rd_nxt  = rd_r + 1'b1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_comb begin
    case (rd_r)
      2'd1:    data_o = data_r[1];
      2'd2:    data_o = data_r[2];
      default: data_o = data_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      data_r <= load_data_i;
    end
  end

endmodule

/* rtl/core/query_text_tokenizer.sv */
// ----------------------------------------------------------------------------
// query_text_tokenizer
// Splits query text into tagged token bytes with first/last marks.
// ----------------------------------------------------------------------------
// Bytes enter a one-item input register; the lexer logic turns the byte and
// the lexer state into up to three results, which land in a three-entry
// result buffer that drives the output channel. Bytes that give zero or one
// result stream at one per cycle while the output channel takes every result;
// a byte that gives two or three results (a token closed plus a one-byte
// token, or an end-of-text marker) holds the next byte until the single
// output port has drained the result buffer. The first result of a byte is
// presented once the byte has passed the input register and been loaded
// into the result buffer. Output stalls back up into the input.
module query_text_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  qtt_in_if.sink    in_ch,
  qtt_out_if.source out_ch
);
  import qtt_pkg::*;

  logic                 in_vld_r, in_vld_nxt;
  logic [7:0]           in_char_r;
  logic                 in_last_r;
  lex_state_t           state_r;
  lex_state_t           state_nxt;
  qtt_result_t          res [MAX_RESULTS];
  logic [RES_CNT_W-1:0] res_cnt;
  logic                 buf_free;
  logic                 take;
  logic                 in_fire;
  qtt_result_t          out_res;

  assign take         = in_vld_r && buf_free;
  assign in_ch.ready  = !in_vld_r || take;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_vld_nxt   = in_fire ? 1'b1 : (take ? 1'b0 : in_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      state_r  <= LEX_RESET;
    end else begin
      in_vld_r <= in_vld_nxt;
      if (take) state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_char_r <= in_ch.in_char;
      in_last_r <= in_ch.in_last;
    end
  end

  qtt_lexer u_lexer (
    .st_i      (state_r),
    .in_char_i (in_char_r),
    .in_last_i (in_last_r),
    .st_nxt_o  (state_nxt),
    .res_o     (res),
    .res_cnt_o (res_cnt)
  );

  qtt_result_buf u_result_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (take),
    .load_cnt_i  (res_cnt),
    .load_data_i (res),
    .pop_i       (out_ch.ready),
    .valid_o     (out_ch.valid),
    .data_o      (out_res),
    .free_o      (buf_free)
  );

  assign out_ch.out_char      = out_res.out_char;
  assign out_ch.token_class   = out_res.token_class;
  assign out_ch.token_first   = out_res.token_first;
  assign out_ch.token_last    = out_res.token_last;
  assign out_ch.keyword_index = out_res.keyword_index;
  assign out_ch.text_end      = out_res.text_end;
  assign out_ch.error_code    = out_res.error_code;

endmodule

/* rtl/core/qtt_checker.sv */
// ----------------------------------------------------------------------------
// qtt_checker
// Port-level checks on the query text tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module qtt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic [3:0] token_class,
  input logic       token_first,
  input logic       token_last,
  input logic       keyword_index,
  input logic       text_end,
  input logic [1:0] error_code
);
  import qtt_pkg::*;

  // a waiting result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_char, token_class, token_first, token_last, keyword_index,
               text_end, error_code}))
    else $error("result changed while stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // input only stalls when results are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // keyword index set only on the closing byte of a keyword
  a_kw_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && keyword_index |-> (token_class == CL_KEYWORD) && token_last)
    else $error("keyword index on a non-keyword result");

endmodule

bind query_text_tokenizer qtt_checker u_qtt_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_char      (out_ch.out_char),
  .token_class   (out_ch.token_class),
  .token_first   (out_ch.token_first),
  .token_last    (out_ch.token_last),
  .keyword_index (out_ch.keyword_index),
  .text_end      (out_ch.text_end),
  .error_code    (out_ch.error_code)
);
